/* rtl/msis_pkg.sv */
// Package for the MIPS subset instruction step block.
// Holds payload structs, status codes, opcodes and address decode helpers.
package msis_pkg;

   localparam int unsigned RegionWordsDefault = 16384;
   localparam logic [31:0] StartPcReset = 32'h0040_0000;
   localparam logic [31:0] SpReset      = 32'h8000_0000;
   localparam logic [31:0] RaReset      = 32'h0040_0018;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_SYSCALL = 3'd1;
   localparam logic [2:0] ST_UNDEF   = 3'd2;
   localparam logic [2:0] ST_NOMEM   = 3'd3;
   localparam logic [2:0] ST_ALIGN   = 3'd4;
   localparam logic [2:0] ST_HALTED  = 3'd5;

   localparam logic [11:0] SelProgram = 12'h004;
   localparam logic [11:0] SelData    = 12'h100;
   localparam logic [11:0] SelStack   = 12'h7FF;

   localparam logic [5:0] OP_SPECIAL = 6'd0;
   localparam logic [5:0] OP_BLTZ    = 6'd1;
   localparam logic [5:0] OP_J       = 6'd2;
   localparam logic [5:0] OP_JAL     = 6'd3;
   localparam logic [5:0] OP_BEQ     = 6'd4;
   localparam logic [5:0] OP_BNE     = 6'd5;
   localparam logic [5:0] OP_ADDI    = 6'd8;
   localparam logic [5:0] OP_ADDIU   = 6'd9;
   localparam logic [5:0] OP_SLTI    = 6'd10;
   localparam logic [5:0] OP_ANDI    = 6'd12;
   localparam logic [5:0] OP_ORI     = 6'd13;
   localparam logic [5:0] OP_XORI    = 6'd14;
   localparam logic [5:0] OP_LUI     = 6'd15;
   localparam logic [5:0] OP_LB      = 6'd32;
   localparam logic [5:0] OP_LW      = 6'd35;
   localparam logic [5:0] OP_LBU     = 6'd36;
   localparam logic [5:0] OP_SB      = 6'd40;
   localparam logic [5:0] OP_SW      = 6'd43;

   localparam logic [5:0] FN_SLL     = 6'd0;
   localparam logic [5:0] FN_SRL     = 6'd2;
   localparam logic [5:0] FN_SRA     = 6'd3;
   localparam logic [5:0] FN_JR      = 6'd8;
   localparam logic [5:0] FN_SYSCALL = 6'd12;
   localparam logic [5:0] FN_MUL     = 6'd24;
   localparam logic [5:0] FN_ADD     = 6'd32;
   localparam logic [5:0] FN_ADDU    = 6'd33;
   localparam logic [5:0] FN_SUB     = 6'd34;
   localparam logic [5:0] FN_AND     = 6'd36;
   localparam logic [5:0] FN_OR      = 6'd37;
   localparam logic [5:0] FN_XOR     = 6'd38;
   localparam logic [5:0] FN_NOR     = 6'd39;
   localparam logic [5:0] FN_SLT     = 6'd42;

   localparam logic REQ_PRELOAD = 1'b0;
   localparam logic REQ_EXECUTE = 1'b1;

   typedef struct packed {
      logic        req_type;
      logic [31:0] load_addr;
      logic [31:0] load_data;
   } req_type_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] next_pc;
      logic        reg_written;
      logic [4:0]  reg_index;
      logic [31:0] reg_value;
      logic        mem_written;
      logic [31:0] mem_addr;
      logic [31:0] mem_value;
   } rsp_type;

   // Region select: 0 program, 1 data, 2 stack; status of decode
   typedef struct packed {
      logic [2:0] status;
      logic [1:0] region;
   } decode_type;

   function automatic decode_type addr_decode(input logic [31:0] a, input logic word,
                                              input logic [31:0] limit);
      decode_type d;
      d.status = ST_OK;
      d.region = 2'd0;
      if (a[31:20] == SelProgram) d.region = 2'd0;
      else if (a[31:20] == SelData) d.region = 2'd1;
      else if (a[31:20] == SelStack) d.region = 2'd2;
      else d.status = ST_NOMEM;
      if (d.status == ST_OK && {12'd0, a[19:0]} >= limit) d.status = ST_NOMEM;
      else if (d.status == ST_OK && word && a[1:0] != 2'd0) d.status = ST_ALIGN;
      return d;
   endfunction

endpackage

/* rtl/msis_mem.sv */
// Word memory of the three regions, one synchronous read/write port.
// Does not depend on msis_pkg; holds the array itself.
module msis_mem #(
   parameter int unsigned AW = 16
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] addr,
   input  logic [31:0]   wr_data,
   output logic [31:0]   rd_data
);
   logic [31:0] mem [2**AW];

   // Read-first single port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule

/* rtl/mips_subset_instruction_step.sv */
// Top level: MIPS32 integer subset stepper, one instruction or preload per transaction.
// Depends on msis_pkg and msis_mem.
//
//   channel | ports                          | direction
//   req     | start, busy, req_payload       | in, start accepted when !busy
//   rsp     | rsp_strobe, rsp_payload        | out, one-cycle strobe
//   csr     | csr_write_en, csr_write_data   | in, start_pc
//
// Preload, halted and fetch-fault transactions go from accept to the next accept
// through the result register, then the strobe. Execute: fetch read, rs read, rt read,
// execute and write back, result register, strobe; lb, lbu, lw and sb with a valid
// address add a data-read step before execute, as memory and register file have one port each.
// Reset loads PC from the start_pc reset value and clears the register file, setting sp and ra
// to their reset values, during which busy is high. Results cannot be stalled.
module mips_subset_instruction_step #(
   parameter int unsigned REGION_WORDS = msis_pkg::RegionWordsDefault
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  msis_pkg::req_type_type req_payload,
   output logic                   rsp_strobe,
   output msis_pkg::rsp_type      rsp_payload,
   input  logic                   csr_write_en,
   input  logic [31:0]            csr_write_data
);
   import msis_pkg::*;

   localparam int unsigned OffW = $clog2(REGION_WORDS);
   localparam int unsigned AW   = OffW + 2;
   localparam logic [31:0] Limit = 32'(REGION_WORDS * 4);

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_FETCH = 3'd2;
   localparam logic [2:0] S_RS    = 3'd3;
   localparam logic [2:0] S_RT    = 3'd4;
   localparam logic [2:0] S_EXEC  = 3'd5;
   localparam logic [2:0] S_MEM   = 3'd6;
   localparam logic [2:0] S_DONE  = 3'd7;

   logic [2:0]  state_ff, state_in;
   logic [31:0] pc_ff, pc_in;
   logic        halted_ff, halted_in;
   logic [4:0]  clr_ff, clr_in;
   logic [31:0] inst_ff, inst_in;
   logic [31:0] a_ff, a_in;
   logic        rsp_strobe_ff, rsp_strobe_in;
   rsp_type     rsp_ff, rsp_in;

   // Register file: synchronous memory, one port
   logic [31:0] rf [32];
   logic        rf_we;
   logic [4:0]  rf_addr;
   logic [31:0] rf_wd, rf_rd;
   always_ff @(posedge clock) begin
      if (rf_we) begin
         rf[rf_addr] <= rf_wd;
      end
      rf_rd <= rf[rf_addr];
   end

   // Data/program memory
   logic          mem_we;
   logic [AW-1:0] mem_addr;
   logic [31:0]   mem_wd, mem_rd;
   msis_mem #(.AW(AW)) u_mem (
      .clock(clock), .wr_en(mem_we), .addr(mem_addr), .wr_data(mem_wd), .rd_data(mem_rd)
   );

   function automatic logic [AW-1:0] widx(input logic [1:0] region, input logic [31:0] a);
      return {region, a[OffW+1:2]};
   endfunction

   // Decode of current instruction
   logic [5:0]  op, fn;
   logic [4:0]  rs, rt, rd, sh;
   logic [15:0] imm;
   logic [31:0] simm, ea, npc4, b;
   assign op   = inst_ff[31:26];
   assign rs   = inst_ff[25:21];
   assign rt   = inst_ff[20:16];
   assign rd   = inst_ff[15:11];
   assign sh   = inst_ff[10:6];
   assign fn   = inst_ff[5:0];
   assign imm  = inst_ff[15:0];
   assign simm = {{16{imm[15]}}, imm};
   assign ea   = a_ff + simm;
   assign npc4 = pc_ff + 32'd4;
   assign b    = rf_rd;

   logic       is_load, is_store;
   decode_type fetch_d, pre_d, ea_d, tgt_d;
   assign is_load  = (op == OP_LB) || (op == OP_LBU) || (op == OP_LW);
   assign is_store = (op == OP_SB) || (op == OP_SW);
   assign fetch_d  = addr_decode(pc_ff, 1'b1, Limit);
   assign pre_d    = addr_decode(req_payload.load_addr, 1'b1, Limit);
   assign ea_d     = addr_decode(ea, (op == OP_LW) || (op == OP_SW), Limit);

   // ALU and control for the execute step
   logic [31:0] val, tgt, bt;
   logic        dest_v, jump;
   logic [4:0]  dest;
   logic [2:0]  st;
   logic [31:0] prod;
   assign prod = a_ff * b;
   assign bt   = npc4 + {simm[29:0], 2'b00};
   always_comb begin
      val = '0; tgt = '0; dest_v = 1'b0; dest = rd; jump = 1'b0; st = ST_OK;
      case (op)
         OP_SPECIAL: begin
            dest_v = 1'b1;
            case (fn)
               FN_ADD, FN_ADDU: val = a_ff + b;
               FN_SUB: val = a_ff - b;
               FN_MUL: val = prod;
               FN_AND: val = a_ff & b;
               FN_OR:  val = a_ff | b;
               FN_XOR: val = a_ff ^ b;
               FN_NOR: val = ~(a_ff | b);
               FN_SLT: val = {31'd0, $signed(a_ff) < $signed(b)};
               FN_SLL: val = b << sh;
               FN_SRL: val = b >> sh;
               FN_SRA: val = $unsigned($signed(b) >>> sh);
               FN_JR: begin dest_v = 1'b0; jump = 1'b1; tgt = a_ff; end
               FN_SYSCALL: begin dest_v = 1'b0; st = ST_SYSCALL; end
               default: begin dest_v = 1'b0; st = ST_UNDEF; end
            endcase
         end
         OP_J, OP_JAL: begin
            jump = 1'b1;
            tgt = {npc4[31:28], inst_ff[25:0], 2'b00};
            dest_v = (op == OP_JAL); dest = 5'd31; val = npc4;
         end
         OP_BLTZ: begin jump = a_ff[31]; tgt = bt; end
         OP_BEQ:  begin jump = (a_ff == b); tgt = bt; end
         OP_BNE:  begin jump = (a_ff != b); tgt = bt; end
         OP_ADDI, OP_ADDIU: begin dest_v = 1'b1; dest = rt; val = a_ff + simm; end
         OP_SLTI: begin dest_v = 1'b1; dest = rt;
            val = {31'd0, $signed(a_ff) < $signed(simm)}; end
         OP_ANDI: begin dest_v = 1'b1; dest = rt; val = a_ff & {16'd0, imm}; end
         OP_ORI:  begin dest_v = 1'b1; dest = rt; val = a_ff | {16'd0, imm}; end
         OP_XORI: begin dest_v = 1'b1; dest = rt; val = a_ff ^ {16'd0, imm}; end
         OP_LUI:  begin dest_v = 1'b1; dest = rt; val = {imm, 16'd0}; end
         OP_LB, OP_LBU, OP_LW, OP_SB, OP_SW: begin
            st = ea_d.status; dest = rt;
         end
         default: st = ST_UNDEF;
      endcase
   end
   assign tgt_d = addr_decode(tgt, 1'b1, Limit);

   // Load byte extraction (big-endian)
   logic [7:0]  lbyte;
   logic [31:0] lval, sb_word;
   logic [4:0]  bsh;
   assign bsh     = {~ea[1:0], 3'b000};
   assign lbyte   = 8'(mem_rd >> bsh);
   assign lval    = (op == OP_LW) ? mem_rd :
                    (op == OP_LB) ? {{24{lbyte[7]}}, lbyte} : {24'd0, lbyte};
   assign sb_word = (mem_rd & ~(32'hFF << bsh)) | ({24'd0, b[7:0]} << bsh);

   // Sequencer
   always_comb begin
      state_in = state_ff; pc_in = pc_ff; halted_in = halted_ff; clr_in = clr_ff;
      inst_in = inst_ff; a_in = a_ff; rsp_strobe_in = 1'b0; rsp_in = rsp_ff;
      rf_we = 1'b0; rf_addr = rs; rf_wd = '0;
      mem_we = 1'b0; mem_addr = widx(ea_d.region, ea); mem_wd = b;
      case (state_ff)
         S_CLEAR: begin
            rf_we = 1'b1; rf_addr = clr_ff;
            rf_wd = (clr_ff == 5'd29) ? SpReset : (clr_ff == 5'd31) ? RaReset : 32'd0;
            clr_in = clr_ff + 5'd1;
            if (clr_ff == 5'd31) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               rsp_in = '0;
               if (halted_ff) begin
                  rsp_in.status = ST_HALTED; rsp_in.next_pc = pc_ff;
                  state_in = S_DONE;
               end else if (req_payload.req_type == REQ_PRELOAD) begin
                  rsp_in.next_pc = pc_ff;
                  rsp_in.status = pre_d.status;
                  if (pre_d.status != ST_OK) begin
                     halted_in = 1'b1;
                  end else begin
                     mem_we = 1'b1;
                     mem_addr = widx(pre_d.region, req_payload.load_addr);
                     mem_wd = req_payload.load_data;
                     rsp_in.mem_written = 1'b1;
                     rsp_in.mem_addr = req_payload.load_addr;
                     rsp_in.mem_value = req_payload.load_data;
                  end
                  state_in = S_DONE;
               end else begin
                  if (fetch_d.status != ST_OK) begin
                     halted_in = 1'b1; rsp_in.status = fetch_d.status;
                     rsp_in.next_pc = pc_ff; state_in = S_DONE;
                  end else begin
                     mem_addr = widx(fetch_d.region, pc_ff);
                     state_in = S_FETCH;
                  end
               end
            end
         end
         S_FETCH: begin
            inst_in = mem_rd; rf_addr = mem_rd[25:21]; state_in = S_RS;
         end
         S_RS: begin
            a_in = rf_rd; rf_addr = rt; state_in = S_RT;
         end
         S_RT: begin
            // b is valid now; issue data read for loads and sb
            rf_addr = rt;
            if ((is_load || op == OP_SB) && ea_d.status == ST_OK) state_in = S_MEM;
            else state_in = S_EXEC;
         end
         S_MEM: begin
            // hold rt read so b stays valid
            rf_addr = rt; state_in = S_EXEC;
         end
         S_EXEC: begin
            rf_addr = rt;
            rsp_in.status = st;
            pc_in = jump ? tgt : npc4;
            if (st == ST_NOMEM || st == ST_ALIGN) halted_in = 1'b1;
            if (dest_v && dest != 5'd0) begin
               rf_we = 1'b1; rf_addr = dest; rf_wd = val;
               rsp_in.reg_written = 1'b1; rsp_in.reg_index = dest; rsp_in.reg_value = val;
            end
            if (is_load && st == ST_OK && rt != 5'd0) begin
               rf_we = 1'b1; rf_addr = rt; rf_wd = lval;
               rsp_in.reg_written = 1'b1; rsp_in.reg_index = rt; rsp_in.reg_value = lval;
            end
            if (is_store && st == ST_OK) begin
               mem_we = 1'b1;
               mem_wd = (op == OP_SW) ? b : sb_word;
               rsp_in.mem_written = 1'b1; rsp_in.mem_addr = ea;
               rsp_in.mem_value = (op == OP_SW) ? b : {24'd0, b[7:0]};
            end
            if (jump) begin
               rsp_in.status = tgt_d.status;
               if (tgt_d.status != ST_OK) halted_in = 1'b1;
            end
            rsp_in.next_pc = jump ? tgt : npc4;
            state_in = S_DONE;
         end
         S_DONE: begin
            rsp_strobe_in = 1'b1; state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
      if (csr_write_en) pc_in = csr_write_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR; pc_ff <= StartPcReset; halted_ff <= 1'b0;
         clr_ff <= '0; rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff <= state_in; pc_ff <= pc_in; halted_ff <= halted_in;
         clr_ff <= clr_in; rsp_strobe_ff <= rsp_strobe_in;
      end
      inst_ff <= inst_in; a_ff <= a_in; rsp_ff <= rsp_in;
   end

   assign busy        = (state_ff != S_IDLE);
   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;
endmodule
